/* rtl/core/adsr_pkg.sv */
`timescale 1ns / 1ps

package adsr_pkg;

	localparam int FRAC   = 24;
	localparam int ENVW   = FRAC + 2;
	localparam int ONE    = 1 << FRAC;
	localparam int SNAP   = (ONE + 500) / 1000;

	localparam int RATEW  = 18;
	localparam int MSW    = 13;
	localparam int SUSW   = 25;
	localparam int SUS_FULL = 16777216;

	// divider geometry: numerator is 1000 * (value <= ONE), quotient capped to QW bits
	localparam int DENW   = RATEW + MSW;
	localparam int NUMW   = FRAC + 10;
	localparam int QW     = FRAC + 2;
	localparam int UPW    = NUMW - QW;
	localparam int REMW   = DENW + 1;
	localparam int CNTW   = $clog2(QW + 1);

	localparam int ADW    = FRAC;
	localparam int RELW   = FRAC + 1;
	localparam int SUSFW  = FRAC + 1;

	localparam int SUS_SHL = (FRAC >= 24) ? FRAC - 24 : 0;
	localparam int SUS_SHR = (FRAC < 24) ? 24 - FRAC : 0;

	localparam int NREG   = 5;
	localparam int ADDRW  = $clog2(NREG * 4);
	localparam int IDXW   = ADDRW - 2;
	localparam int DATAW  = 32;

	localparam logic [IDXW-1:0] REG_RATE    = IDXW'(0);
	localparam logic [IDXW-1:0] REG_ATTACK  = IDXW'(1);
	localparam logic [IDXW-1:0] REG_DECAY   = IDXW'(2);
	localparam logic [IDXW-1:0] REG_SUSTAIN = IDXW'(3);
	localparam logic [IDXW-1:0] REG_RELEASE = IDXW'(4);

	localparam logic [RATEW-1:0] RATE_RST = RATEW'(44100);
	localparam logic [MSW-1:0]   MS_RST   = MSW'(500);
	localparam logic [SUSW-1:0]  SUS_RST  = SUSW'(8388608);

	typedef struct packed {
		logic [ADW-1:0]  att;
		logic [ADW-1:0]  dec;
		logic [RELW-1:0] rel;
	} steps_t;

	// sustain register (Q0.24, saturated at full scale) to Q.FRAC
	function automatic logic [SUSFW-1:0] sus_fx(input logic [SUSW-1:0] s);
		logic [SUSW-1:0]         c;
		logic [SUSW+SUS_SHL-1:0] t;
		c = (s > SUSW'(SUS_FULL)) ? SUSW'(SUS_FULL) : s;
		t = (SUSW + SUS_SHL)'(c) << SUS_SHL;
		return SUSFW'(t >> SUS_SHR);
	endfunction

endpackage

/* rtl/core/adsr_div.sv */
`timescale 1ns / 1ps

module adsr_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [adsr_pkg::NUMW-1:0]   num,
	input  logic [adsr_pkg::DENW-1:0]   den,
	output logic                        done,
	output logic                        ovf,
	output logic [adsr_pkg::QW-1:0]     quo
);

	logic [adsr_pkg::DENW-1:0] den_q;
	logic [adsr_pkg::REMW-1:0] rem_q;
	logic [adsr_pkg::QW-1:0]   lo_q;
	logic [adsr_pkg::QW-1:0]   quo_q;
	logic [adsr_pkg::CNTW-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic                      ovf_q;

	logic [adsr_pkg::REMW-1:0] rem2;
	logic                      ge;

	// restoring division, one quotient bit a cycle
	assign rem2 = {rem_q[adsr_pkg::REMW-2:0], lo_q[adsr_pkg::QW-1]};
	assign ge   = rem2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= adsr_pkg::CNTW'(adsr_pkg::QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - adsr_pkg::CNTW'(1);
			if (cnt_q == adsr_pkg::CNTW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= adsr_pkg::REMW'(num[adsr_pkg::NUMW-1:adsr_pkg::QW]);
			lo_q  <= num[adsr_pkg::QW-1:0];
			quo_q <= '0;
			// upper numerator bits already hold a whole divisor: quotient too big
			// (also covers a zero divisor)
			ovf_q <= adsr_pkg::DENW'(num[adsr_pkg::NUMW-1:adsr_pkg::QW]) >= den;
		end else if (busy_q) begin
			rem_q <= ge ? rem2 - {1'b0, den_q} : rem2;
			lo_q  <= {lo_q[adsr_pkg::QW-2:0], 1'b0};
			quo_q <= {quo_q[adsr_pkg::QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign quo  = quo_q;

endmodule

/* rtl/core/adsr_steps.sv */
`timescale 1ns / 1ps

module adsr_steps (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         recalc,
	input  logic [adsr_pkg::RATEW-1:0]   rate,
	input  logic [adsr_pkg::MSW-1:0]     att_ms,
	input  logic [adsr_pkg::MSW-1:0]     dec_ms,
	input  logic [adsr_pkg::MSW-1:0]     rel_ms,
	input  logic [adsr_pkg::SUSFW-1:0]   sus,
	output logic                         ready,
	output adsr_pkg::steps_t             steps
);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_WAIT = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [1:0] PH_ATT = 2'd0;
	localparam logic [1:0] PH_DEC = 2'd1;
	localparam logic [1:0] PH_REL = 2'd2;

	logic [1:0] state_q;
	logic [1:0] phase_q;

	adsr_pkg::steps_t steps_q;

	logic [adsr_pkg::MSW-1:0]   ms;
	logic [adsr_pkg::SUSFW-1:0] base;
	logic [adsr_pkg::QW-1:0]    lim;
	logic [adsr_pkg::NUMW-1:0]  num;
	logic [adsr_pkg::DENW-1:0]  den;
	logic                       div_start;
	logic                       div_done;
	logic                       div_ovf;
	logic [adsr_pkg::QW-1:0]    div_quo;
	logic [adsr_pkg::QW-1:0]    qc;

	always_comb begin
		case (phase_q)
			PH_ATT: begin
				ms   = att_ms;
				base = adsr_pkg::SUSFW'(adsr_pkg::ONE);
				lim  = adsr_pkg::QW'(adsr_pkg::ONE / 2);
			end
			PH_DEC: begin
				ms   = dec_ms;
				base = adsr_pkg::SUSFW'(adsr_pkg::ONE) - sus;
				lim  = adsr_pkg::QW'(adsr_pkg::ONE / 2);
			end
			default: begin
				ms   = rel_ms;
				base = sus;
				lim  = adsr_pkg::QW'(adsr_pkg::ONE);
			end
		endcase
	end

	assign num = adsr_pkg::NUMW'(base) * adsr_pkg::NUMW'(1000);
	assign den = adsr_pkg::DENW'(rate) * adsr_pkg::DENW'(ms);
	assign div_start = (state_q == ST_LOAD) && !recalc;

	adsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.ovf    (div_ovf),
		.quo    (div_quo)
	);

	// clamp to [1 LSB, limit]
	always_comb begin
		if (div_ovf || div_quo > lim) begin
			qc = lim;
		end else if (div_quo == '0) begin
			qc = adsr_pkg::QW'(1);
		end else begin
			qc = div_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			phase_q <= PH_ATT;
		end else if (recalc) begin
			state_q <= ST_LOAD;
			phase_q <= PH_ATT;
		end else begin
			case (state_q)
				ST_LOAD: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_done) begin
						if (phase_q == PH_REL) begin
							state_q <= ST_DONE;
						end else begin
							phase_q <= phase_q + 2'd1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_DONE: begin
					state_q <= ST_DONE;
				end
				default: begin
					state_q <= ST_LOAD;
					phase_q <= PH_ATT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT && div_done && !recalc) begin
			case (phase_q)
				PH_ATT:  steps_q.att <= adsr_pkg::ADW'(qc);
				PH_DEC:  steps_q.dec <= adsr_pkg::ADW'(qc);
				default: steps_q.rel <= adsr_pkg::RELW'(qc);
			endcase
		end
	end

	assign ready = (state_q == ST_DONE);
	assign steps = steps_q;

endmodule

/* rtl/core/linear_adsr_envelope.sv */
`timescale 1ns / 1ps

// Linear ADSR envelope, one gate item per audio sample, one result item (envelope in signed
// Q2.24 and the active flag) per item. Items are taken once the step sizes are known and no
// result is held back by out_stall. The attack, decay and release steps are worked out from
// the registers by a shared bit-serial divider, one quotient bit a cycle, three divisions in
// turn: after reset and after every register write the block holds in_stall high while the
// steps are recomputed. Registers are to be written over the APB port only while no item is
// in flight, a rule the block itself leaves to the user.

module linear_adsr_envelope (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [adsr_pkg::ADDRW-1:0]        paddr,
	input  logic [adsr_pkg::DATAW-1:0]        pwdata,
	output logic [adsr_pkg::DATAW-1:0]        prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              gate,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [adsr_pkg::ENVW-1:0]  envelope,
	output logic                              active
);

	localparam int SUMW = adsr_pkg::ENVW + 1;

	logic [adsr_pkg::RATEW-1:0] rate_q;
	logic [adsr_pkg::MSW-1:0]   att_ms_q;
	logic [adsr_pkg::MSW-1:0]   dec_ms_q;
	logic [adsr_pkg::SUSW-1:0]  sus_lvl_q;
	logic [adsr_pkg::MSW-1:0]   rel_ms_q;

	logic                       cfg_wr;
	logic [adsr_pkg::IDXW-1:0]  idx;

	logic signed [adsr_pkg::ENVW-1:0] env_q;
	logic                             att_q;
	logic                             run_q;
	logic                             prev_q;
	logic                             out_valid_q;

	logic                       steps_ready;
	adsr_pkg::steps_t           steps;
	logic [adsr_pkg::SUSFW-1:0] sus;
	logic                       accept;

	logic                             start;
	logic                             att_c;
	logic                             run_c;
	logic signed [SUMW-1:0]           addend;
	logic signed [SUMW-1:0]           sum;
	logic signed [adsr_pkg::ENVW-1:0] sat;
	logic signed [adsr_pkg::ENVW-1:0] sus_snap;
	logic signed [adsr_pkg::ENVW-1:0] rel_neg;
	logic signed [adsr_pkg::ENVW-1:0] env_n;
	logic                             att_n;
	logic                             run_n;

	// register port
	assign cfg_wr = psel & penable & pwrite;
	assign idx    = paddr[adsr_pkg::ADDRW-1:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= adsr_pkg::RATE_RST;
			att_ms_q  <= adsr_pkg::MS_RST;
			dec_ms_q  <= adsr_pkg::MS_RST;
			sus_lvl_q <= adsr_pkg::SUS_RST;
			rel_ms_q  <= adsr_pkg::MS_RST;
		end else if (cfg_wr) begin
			case (idx)
				adsr_pkg::REG_RATE:    rate_q    <= pwdata[adsr_pkg::RATEW-1:0];
				adsr_pkg::REG_ATTACK:  att_ms_q  <= pwdata[adsr_pkg::MSW-1:0];
				adsr_pkg::REG_DECAY:   dec_ms_q  <= pwdata[adsr_pkg::MSW-1:0];
				adsr_pkg::REG_SUSTAIN: sus_lvl_q <= pwdata[adsr_pkg::SUSW-1:0];
				adsr_pkg::REG_RELEASE: rel_ms_q  <= pwdata[adsr_pkg::MSW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			adsr_pkg::REG_RATE:    prdata = adsr_pkg::DATAW'(rate_q);
			adsr_pkg::REG_ATTACK:  prdata = adsr_pkg::DATAW'(att_ms_q);
			adsr_pkg::REG_DECAY:   prdata = adsr_pkg::DATAW'(dec_ms_q);
			adsr_pkg::REG_SUSTAIN: prdata = adsr_pkg::DATAW'(sus_lvl_q);
			adsr_pkg::REG_RELEASE: prdata = adsr_pkg::DATAW'(rel_ms_q);
			default:               prdata = '0;
		endcase
	end

	assign sus = adsr_pkg::sus_fx(sus_lvl_q);

	adsr_steps u_steps (
		.clk    (clk),
		.arst_n (arst_n),
		.recalc (cfg_wr),
		.rate   (rate_q),
		.att_ms (att_ms_q),
		.dec_ms (dec_ms_q),
		.rel_ms (rel_ms_q),
		.sus    (sus),
		.ready  (steps_ready),
		.steps  (steps)
	);

	// handshake: the state registers double as the output register
	assign in_stall = ~steps_ready | (out_valid_q & out_stall);
	assign accept   = in_valid & ~in_stall;

	// one sample of the envelope
	always_comb begin
		start = gate & ~prev_q;
		att_c = att_q | start;
		run_c = run_q | start;

		if (!gate) begin
			addend = -$signed({2'b00, steps.rel});
		end else if (att_c) begin
			addend = $signed({3'b000, steps.att});
		end else begin
			addend = -$signed({3'b000, steps.dec});
		end

		sum = $signed({env_q[adsr_pkg::ENVW-1], env_q}) + addend;
		if (sum[SUMW-1] != sum[SUMW-2]) begin
			sat = sum[SUMW-1] ? {1'b1, {(adsr_pkg::ENVW-1){1'b0}}}
			                  : {1'b0, {(adsr_pkg::ENVW-1){1'b1}}};
		end else begin
			sat = sum[adsr_pkg::ENVW-1:0];
		end

		sus_snap = $signed(adsr_pkg::ENVW'(sus)) + $signed(adsr_pkg::ENVW'(adsr_pkg::SNAP));
		rel_neg  = -$signed({1'b0, steps.rel});

		env_n = env_q;
		att_n = att_c;
		run_n = run_c;
		if (run_c) begin
			if (gate) begin
				if (att_c) begin
					env_n = sat;
					if (sat >= $signed(adsr_pkg::ENVW'(adsr_pkg::ONE))) begin
						att_n = 1'b0;
					end
				end else if (env_q <= sus_snap) begin
					env_n = $signed({1'b0, sus});
				end else begin
					env_n = sat;
				end
			end else begin
				env_n = sat;
				if (sat <= rel_neg) begin
					run_n = 1'b0;
				end
			end
		end else begin
			env_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q       <= '0;
			att_q       <= 1'b0;
			run_q       <= 1'b0;
			prev_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				env_q       <= env_n;
				att_q       <= att_n;
				run_q       <= run_n;
				prev_q      <= gate;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign envelope  = env_q;
	assign active    = run_q;

endmodule

/* rtl/core/adsr_chk.sv */
`timescale 1ns / 1ps

module adsr_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [adsr_pkg::ENVW-1:0]  envelope,
	input  logic                              active
);

	// no item taken while a result sits unclaimed
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && !in_stall && out_valid && out_stall))
		else $error("item accepted while output held");

	// every accepted item shows its result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("result missing after accepted item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(envelope) && $stable(active)))
		else $error("stalled result changed");

endmodule

bind linear_adsr_envelope adsr_chk u_adsr_chk (.*);

/* verif/tb_linear_adsr_envelope.sv */
`timescale 1ns / 1ps

module tb_linear_adsr_envelope;
	import adsr_pkg::*;

	localparam int     WATCHDOG_LIMIT = 4000;
	localparam int     NPHASES        = 12;
	localparam longint ENV_HI         = (longint'(1) <<< (ENVW - 1)) - 1;
	localparam longint ENV_LO         = -(longint'(1) <<< (ENVW - 1));
	localparam longint ONE_L          = longint'(ONE);
	localparam int     SUS_MAXREG     = (1 << SUSW) - 1;

	typedef struct packed {
		logic signed [ENVW-1:0] env;
		logic                   act;
	} env_sample_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [ADDRW-1:0]        paddr = '0;
	logic [DATAW-1:0]        pwdata = '0;
	logic [DATAW-1:0]        prdata;
	logic                    pready;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    gate = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b1;
	logic signed [ENVW-1:0]  envelope;
	logic                    active;

	linear_adsr_envelope dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.gate(gate),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.envelope(envelope),
		.active(active)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// register copies and envelope state kept by the testbench
	logic [RATEW-1:0] cfg_rate    = RATE_RST;
	logic [MSW-1:0]   cfg_attack  = MS_RST;
	logic [MSW-1:0]   cfg_decay   = MS_RST;
	logic [SUSW-1:0]  cfg_sustain = SUS_RST;
	logic [MSW-1:0]   cfg_release = MS_RST;

	longint env_acc    = 0;
	bit     attacking  = 1'b0;
	bit     running_st = 1'b0;
	bit     gate_prev  = 1'b1;

	bit          gate_q[$];
	env_sample_t envelope_q[$];

	int mismatches   = 0;
	int results_seen = 0;
	bit send_idle    = 1'b1;
	bit recv_idle    = 1'b1;

	function automatic longint step_size(longint unsigned num, longint unsigned ms, longint lim);
		longint unsigned den;
		longint unsigned q;
		den = longint'(cfg_rate) * ms;
		if (den == 0)
			return lim;
		q = (64'd1000 * num) / den;
		if (q > longint'(lim))
			return lim;
		if (q == 0)
			return 1;
		return longint'(q);
	endfunction

	function automatic longint sat_envelope(longint v);
		if (v > ENV_HI)
			return ENV_HI;
		if (v < ENV_LO)
			return ENV_LO;
		return v;
	endfunction

	function automatic void advance_envelope(bit g);
		longint sus;
		longint a_step;
		longint d_step;
		longint r_step;
		env_sample_t s;
		sus = (cfg_sustain > SUSW'(SUS_FULL)) ? longint'(SUS_FULL) : longint'(cfg_sustain);
		sus = (sus <<< SUS_SHL) >>> SUS_SHR;
		a_step = step_size(ONE_L, cfg_attack, ONE_L / 2);
		d_step = -step_size(ONE_L - sus, cfg_decay, ONE_L / 2);
		r_step = -step_size(sus, cfg_release, ONE_L);

		if (g && !gate_prev) begin
			attacking  = 1'b1;
			running_st = 1'b1;
		end
		gate_prev = g;

		if (running_st) begin
			if (g) begin
				if (attacking) begin
					env_acc = sat_envelope(env_acc + a_step);
					if (env_acc >= ONE_L)
						attacking = 1'b0;
				end else if (env_acc <= sus + SNAP) begin
					env_acc = sus;
				end else begin
					env_acc = sat_envelope(env_acc + d_step);
				end
			end else begin
				env_acc = sat_envelope(env_acc + r_step);
				if (env_acc <= r_step)
					running_st = 1'b0;
			end
		end else begin
			env_acc = 0;
		end

		s.env = ENVW'(env_acc);
		s.act = running_st;
		envelope_q.push_back(s);
	endfunction

	// sender: one gate item per handshake, a random gap after each while send_idle is set
	int send_gap = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				advance_envelope(gate);
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap = send_gap - 1;
					in_valid <= 1'b0;
				end else if (gate_q.size() != 0) begin
					in_valid <= 1'b1;
					gate <= gate_q.pop_front();
					send_gap = send_idle ? $urandom_range(0, 11) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: compare each result item, random stalls, one long hold-off
	int  recv_wait = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	env_sample_t want;
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (envelope_q.size() == 0) begin
					$display("%0t: result with none expected: envelope %0d active %0b",
						$time, envelope, active);
					mismatches++;
				end else begin
					want = envelope_q.pop_front();
					if (envelope !== want.env) begin
						$display("%0t: envelope expected %0d actual %0d", $time, want.env, envelope);
						mismatches++;
					end
					if (active !== want.act) begin
						$display("%0t: active expected %0b actual %0b", $time, want.act, active);
						mismatches++;
					end
				end
				recv_wait = recv_idle ? $urandom_range(0, 11) : 0;
			end
			// hold off long enough that the block backs up into its input
			if (!hold_done && results_seen > 200 && gate_q.size() > 40) begin
				hold_left = 300;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (recv_wait > 0) begin
				recv_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic apb_write(input logic [IDXW-1:0] idx, input logic [DATAW-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_RATE:    cfg_rate    = val[RATEW-1:0];
			REG_ATTACK:  cfg_attack  = val[MSW-1:0];
			REG_DECAY:   cfg_decay   = val[MSW-1:0];
			REG_SUSTAIN: cfg_sustain = val[SUSW-1:0];
			REG_RELEASE: cfg_release = val[MSW-1:0];
			default: ;
		endcase
	endtask

	task automatic set_registers(input int rate, input int att, input int dec, input int sus,
		input int rel);
		apb_write(REG_RATE, rate);
		apb_write(REG_ATTACK, att);
		apb_write(REG_DECAY, dec);
		apb_write(REG_SUSTAIN, sus);
		apb_write(REG_RELEASE, rel);
	endtask

	task automatic drain();
		while (gate_q.size() != 0 || in_valid || envelope_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic push_pattern(input logic [31:0] pat, input int len);
		for (int i = len - 1; i >= 0; i--)
			gate_q.push_back(pat[i]);
	endtask

	// mostly note-like runs of high then low gate, some random noise
	task automatic queue_gates(input int n);
		int k;
		int len;
		k = 0;
		while (k < n) begin
			if ($urandom_range(0, 4) == 0) begin
				len = $urandom_range(1, 6);
				repeat (len) gate_q.push_back($urandom_range(0, 1));
				k += len;
			end else begin
				len = $urandom_range(1, 40);
				repeat (len) gate_q.push_back(1'b1);
				k += len;
				len = $urandom_range(1, 40);
				repeat (len) gate_q.push_back(1'b0);
				k += len;
			end
		end
	endtask

	function automatic int pick_ms();
		return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 5000) : $urandom_range(0, 40);
	endfunction

	initial begin
		int rate;
		int sus;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings; gate high at start must not trigger
		push_pattern(32'b11011001, 8);
		drain();

		// zero times: step limits, two-sample attack, snap to sustain, release end
		set_registers(1000, 0, 0, SUS_FULL / 4, 0);
		push_pattern(32'b01111110001011, 14);
		drain();

		for (int p = 0; p < NPHASES; p++) begin
			case (p)
				0: set_registers(192000, 5000, 5000, 0, 5000);        // tiny steps
				1: set_registers(0, pick_ms(), pick_ms(), SUS_FULL / 2, pick_ms());
				2: set_registers(1, 1, 1, SUS_MAXREG, 1);             // sustain above full
				3: set_registers(1000, 20, 20, SUS_FULL, 20);
				default: begin
					rate = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 192000)
						: $urandom_range(1, 1000);
					case ($urandom_range(0, 5))
						0: sus = 0;
						1: sus = SUS_FULL;
						2: sus = $urandom_range(SUS_FULL, SUS_MAXREG);
						default: sus = $urandom_range(0, SUS_FULL);
					endcase
					set_registers(rate, pick_ms(), pick_ms(), sus, pick_ms());
				end
			endcase
			send_idle = $urandom_range(0, 3) != 0;
			recv_idle = $urandom_range(0, 3) != 0;
			queue_gates($urandom_range(100, 150));
			drain();
		end

		repeat (50) @(posedge clk);
		if (mismatches == 0 && envelope_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
